// ===== rtl/core/wsar_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wsar_pkg;

  // register map
  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_WINDOW_LENGTH = 2'd0;
  localparam reg_index_t REG_DEADBAND      = 2'd1;
  localparam reg_index_t REG_HEARTBEAT     = 2'd2;

  localparam int unsigned REG_DATA_W = 16;

  // register reset values
  localparam logic [4:0]  WINDOW_LENGTH_RST = 5'd5;
  localparam logic [15:0] DEADBAND_RST      = 16'd26;
  localparam logic [15:0] HEARTBEAT_RST     = 16'd30;

  localparam int unsigned PERCENT_SCALE = 100;
  localparam logic [15:0] ERR_TOP       = 16'hFFFF;

  // one sample word
  typedef struct packed {
    logic               read_ok;
    logic signed [11:0] sample_value;
    logic [31:0]        now_seconds;
    logic               link_ready;
  } sample_t;

  // one window result word
  typedef struct packed {
    logic signed [15:0] average;
    logic               report_temperature;
    logic [6:0]         correctness_percent;
    logic               correctness_changed;
    logic [15:0]        error_total;
    logic               errors_changed;
    logic               window_empty;
  } result_t;

  // window-end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_DECIDE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/wsar_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// sample stream
interface wsar_sample_if;
  import wsar_pkg::*;
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// window result stream
interface wsar_result_if;
  import wsar_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// register write channel
interface wsar_reg_if;
  import wsar_pkg::*;
  logic                  valid;
  logic                  ready;
  reg_index_t            index;
  logic [REG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wsar_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// unsigned restoring divider, one quotient bit per cycle
module wsar_div #(
  parameter int DIV_W = 20,
  parameter int DEN_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // one trial subtract per cycle
  always_comb begin
    rem_sh  = {rem, work[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, den};
    ge      = (rem_sh >= {1'b0, den});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      den  <= divisor;
    end else if (busy) begin
      work <= {work[DIV_W-2:0], ge};
      rem  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign quotient = work;

endmodule

`default_nettype wire

// ===== rtl/core/wsar_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none

// window sum, good count, position and saturating error count
module wsar_acc #(
  parameter int SUM_W = 16,
  parameter int CW    = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    take,
  input  wire logic                    clear,
  input  wire logic                    read_ok,
  input  wire logic signed [11:0]      sample_value,
  output logic signed      [SUM_W-1:0] sum,
  output logic             [CW-1:0]    count,
  output logic             [CW-1:0]    position,
  output logic             [15:0]      error_count
);
  import wsar_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum         <= '0;
      count       <= '0;
      position    <= '0;
      error_count <= '0;
    end else if (clear) begin
      sum      <= '0;
      count    <= '0;
      position <= '0;
    end else if (take) begin
      position <= position + CW'(1);
      if (read_ok) begin
        sum   <= sum + SUM_W'(sample_value);
        count <= count + CW'(1);
      end else if (error_count != ERR_TOP) begin
        error_count <= error_count + 16'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/windowed_sensor_average_reporter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Windowed temperature averager and report scheduler. Each accepted sample word
// is summed (good reading) or counted as an error; samples that do not close
// the window are taken one per cycle. The sample that closes the window triggers
// two passes of a one-bit-per-cycle divider (average, then correctness percent)
// of SUM_W+4 bits, with SUM_W = 12 + clog2(MAX_WINDOW), between control states;
// an empty window skips the average pass. Samples are not taken during that
// sequence; a finished result sits in an output register, and the next sample
// is taken while it waits. The register channel is always ready and should be
// written only while idle.
module windowed_sensor_average_reporter #(
  parameter int MAX_WINDOW = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  wsar_sample_if.sink    samples,
  wsar_result_if.source  results,
  wsar_reg_if.sink       regs
);
  import wsar_pkg::*;

  localparam int SUM_W = 12 + $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int CW1   = CW + 1;
  localparam int DIV_W = SUM_W + 4;

  // registers
  logic [4:0]  window_length;
  logic [15:0] deadband;
  logic [15:0] heartbeat_seconds;

  // report state
  logic signed [15:0] current_average;
  logic signed [15:0] last_sent_average;
  logic [31:0]        last_send_time;
  logic [15:0]        reported_error_count;
  logic [6:0]         reported_correctness;

  // per-window working values
  logic [31:0]        now_lat;
  logic               link_lat;
  logic               empty_lat;
  logic signed [15:0] avg_new;
  logic [6:0]         percent;

  state_t state, state_next;

  logic                    take;
  logic                    acc_clear;
  logic signed [SUM_W-1:0] acc_sum;
  logic [CW-1:0]           acc_count;
  logic [CW-1:0]           acc_position;
  logic [15:0]             error_count;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [CW-1:0]    div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quotient;

  logic [CW-1:0]    len;
  logic             window_end;
  logic [SUM_W-1:0] sum_bits;
  logic [SUM_W-1:0] abs_sum;
  logic [15:0]      q16;
  logic [15:0]      avg_calc;
  logic [16:0]      diff;
  logic [16:0]      mag;
  logic [31:0]      elapsed;
  logic             send;
  logic             fire;
  logic             out_valid;
  result_t          out_data;

  // register writes
  assign regs.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= WINDOW_LENGTH_RST;
      deadband          <= DEADBAND_RST;
      heartbeat_seconds <= HEARTBEAT_RST;
    end else if (regs.valid) begin
      unique case (regs.index)
        REG_WINDOW_LENGTH: window_length     <= regs.data[4:0];
        REG_DEADBAND:      deadband          <= regs.data;
        REG_HEARTBEAT:     heartbeat_seconds <= regs.data;
        default: ;
      endcase
    end
  end

  // effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_length == 5'd0) begin
      len = CW'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      len = CW'(MAX_WINDOW);
    end else begin
      len = CW'(window_length);
    end
  end

  assign take       = samples.valid && samples.ready;
  assign window_end = ({1'b0, acc_position} + CW1'(1)) >= {1'b0, len};

  wsar_acc #(
    .SUM_W (SUM_W),
    .CW    (CW)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .clear        (acc_clear),
    .read_ok      (samples.data.read_ok),
    .sample_value (samples.data.sample_value),
    .sum          (acc_sum),
    .count        (acc_count),
    .position     (acc_position),
    .error_count  (error_count)
  );

  // divider operands: sum magnitude times 16, or good count times 100
  always_comb begin
    sum_bits = acc_sum;
    abs_sum  = sum_bits[SUM_W-1] ? (~sum_bits + SUM_W'(1)) : sum_bits;
    if (state == ST_PCT_GO) begin
      div_dividend = DIV_W'(acc_count) * DIV_W'(PERCENT_SCALE);
      div_divisor  = len;
    end else begin
      div_dividend = {abs_sum, 4'b0000};
      div_divisor  = acc_count;
    end
  end

  wsar_div #(
    .DIV_W (DIV_W),
    .DEN_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // signed average from the quotient
  assign q16      = div_quotient[15:0];
  assign avg_calc = sum_bits[SUM_W-1] ? (~q16 + 16'd1) : q16;

  // report decision
  always_comb begin
    diff    = {avg_new[15], avg_new} - {last_sent_average[15], last_sent_average};
    mag     = diff[16] ? (~diff + 17'd1) : diff;
    elapsed = now_lat - last_send_time;
    send    = !empty_lat && link_lat &&
              ((mag >= {1'b0, deadband}) || (elapsed >= {16'd0, heartbeat_seconds}));
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    div_start     = 1'b0;
    acc_clear     = 1'b0;
    fire          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid && window_end) begin
          state_next = ST_AVG_GO;
        end
      end
      ST_AVG_GO: begin
        if (acc_count == '0) begin
          state_next = ST_PCT_GO;
        end else begin
          div_start  = 1'b1;
          state_next = ST_AVG_WAIT;
        end
      end
      ST_AVG_WAIT: begin
        if (div_done) begin
          state_next = ST_PCT_GO;
        end
      end
      ST_PCT_GO: begin
        div_start  = 1'b1;
        state_next = ST_PCT_WAIT;
      end
      ST_PCT_WAIT: begin
        if (div_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_valid || results.ready) begin
          fire       = 1'b1;
          acc_clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // per-window working values
  always_ff @(posedge clk) begin
    if (take && window_end) begin
      now_lat  <= samples.data.now_seconds;
      link_lat <= samples.data.link_ready;
    end
    if (state == ST_AVG_GO) begin
      empty_lat <= (acc_count == '0);
    end
    if (state == ST_AVG_WAIT && div_done) begin
      avg_new <= avg_calc;
    end
    if (state == ST_PCT_WAIT && div_done) begin
      percent <= div_quotient[6:0];
    end
  end

  // report state update at window end
  always_ff @(posedge clk) begin
    if (rst) begin
      current_average      <= '0;
      last_sent_average    <= '0;
      last_send_time       <= '0;
      reported_error_count <= '0;
      reported_correctness <= '0;
    end else if (fire) begin
      if (!empty_lat) begin
        current_average <= avg_new;
      end
      if (send) begin
        last_sent_average <= avg_new;
        last_send_time    <= now_lat;
      end
      reported_error_count <= error_count;
      reported_correctness <= percent;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.average             <= empty_lat ? current_average : avg_new;
      out_data.report_temperature  <= send;
      out_data.correctness_percent <= percent;
      out_data.correctness_changed <= (percent != reported_correctness);
      out_data.error_total         <= error_count;
      out_data.errors_changed      <= (error_count != reported_error_count);
      out_data.window_empty        <= empty_lat;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

endmodule

`default_nettype wire

// ===== tb/sv/wsar_window_checker.sv =====
`timescale 1ns / 1ps

// watches the sample, result and register channels, predicts each window
// result and compares it with what the block delivers
module wsar_window_checker
  import wsar_pkg::*;
#(
  parameter int MAX_WINDOW = 16
) (
  input  logic      clk,
  input  logic      rst,
  wsar_sample_if    samples,
  wsar_result_if    results,
  wsar_reg_if       regs,
  output int        fail_count,
  output int        pending
);

  // register copies
  logic [4:0]  window_length_q;
  logic [15:0] deadband_q;
  logic [15:0] heartbeat_q;

  // window and report state
  int                 sum_acc;
  int                 good_n;
  int                 pos_n;
  logic [15:0]        err_n;
  logic [15:0]        err_reported;
  logic [6:0]         pct_reported;
  logic signed [15:0] avg_now;
  logic signed [15:0] avg_sent;
  logic [31:0]        sent_time;

  result_t expected_windows[$];
  result_t want;
  int      mismatches = 0;
  int      pending_q = 0;

  assign fail_count = mismatches;
  assign pending    = pending_q;

  // fold one sample word into the window, queue a result at window end
  task automatic absorb_sample(input sample_t s);
    int          len;
    int          diff;
    int          mag;
    int          pct;
    logic [31:0] elapsed;
    result_t     r;
    len = (window_length_q == 5'd0) ? 1 :
          (int'(window_length_q) > MAX_WINDOW) ? MAX_WINDOW : int'(window_length_q);
    if (s.read_ok) begin
      sum_acc += $signed(s.sample_value);
      good_n++;
    end else if (err_n != ERR_TOP) begin
      err_n++;
    end
    pos_n++;
    if (pos_n < len) return;

    r = '0;
    r.window_empty = (good_n == 0);
    // empty window holds the average and leaves the last sent average and time alone
    if (good_n != 0) begin
      avg_now = 16'((sum_acc * 16) / good_n);
      diff    = int'(avg_now) - int'(avg_sent);
      mag     = (diff < 0) ? -diff : diff;
      elapsed = s.now_seconds - sent_time;
      if ((mag >= int'(deadband_q) || elapsed >= {16'd0, heartbeat_q}) && s.link_ready) begin
        r.report_temperature = 1'b1;
        avg_sent  = avg_now;
        sent_time = s.now_seconds;
      end
    end
    pct = (good_n * int'(PERCENT_SCALE)) / len;
    r.average             = avg_now;
    r.correctness_percent = 7'(pct);
    r.correctness_changed = (7'(pct) != pct_reported);
    pct_reported          = 7'(pct);
    r.error_total         = err_n;
    r.errors_changed      = (err_n != err_reported);
    err_reported          = err_n;
    sum_acc = 0;
    good_n  = 0;
    pos_n   = 0;
    expected_windows.push_back(r);
  endtask

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      window_length_q = WINDOW_LENGTH_RST;
      deadband_q      = DEADBAND_RST;
      heartbeat_q     = HEARTBEAT_RST;
      sum_acc         = 0;
      good_n          = 0;
      pos_n           = 0;
      err_n           = '0;
      err_reported    = '0;
      pct_reported    = '0;
      avg_now         = '0;
      avg_sent        = '0;
      sent_time       = '0;
      expected_windows.delete();
    end else begin
      // compare a delivered result word with the oldest prediction
      if (results.valid && results.ready) begin
        if (expected_windows.size() == 0) begin
          $display("%0t: result word with no window pending: 0x%0h", $time, results.data);
          mismatches++;
        end else begin
          want = expected_windows.pop_front();
          check_field("average", {{16{want.average[15]}}, want.average},
                      {{16{results.data.average[15]}}, results.data.average});
          check_field("report_temperature", 32'(want.report_temperature),
                      32'(results.data.report_temperature));
          check_field("correctness_percent", 32'(want.correctness_percent),
                      32'(results.data.correctness_percent));
          check_field("correctness_changed", 32'(want.correctness_changed),
                      32'(results.data.correctness_changed));
          check_field("error_total", 32'(want.error_total), 32'(results.data.error_total));
          check_field("errors_changed", 32'(want.errors_changed),
                      32'(results.data.errors_changed));
          check_field("window_empty", 32'(want.window_empty), 32'(results.data.window_empty));
        end
      end
      // register writes
      if (regs.valid && regs.ready) begin
        case (regs.index)
          REG_WINDOW_LENGTH: window_length_q = regs.data[4:0];
          REG_DEADBAND:      deadband_q      = regs.data;
          REG_HEARTBEAT:     heartbeat_q     = regs.data;
          default: ;
        endcase
      end
      // accepted sample words
      if (samples.valid && samples.ready) absorb_sample(samples.data);
    end
    pending_q <= expected_windows.size();
  end

endmodule

// ===== tb/sv/tb_windowed_sensor_average_reporter.sv =====
`timescale 1ns / 1ps

module tb_windowed_sensor_average_reporter;
  import wsar_pkg::*;

  localparam reg_index_t REG_UNUSED  = 2'd3;
  localparam int         HOLD_CYCLES = 400;
  localparam int         DRAIN_CYCLES = 60;
  localparam int         RUN_LIMIT_NS = 20_000_000;

  logic clk;
  logic rst;

  wsar_sample_if sample_ch ();
  wsar_result_if window_ch ();
  wsar_reg_if    reg_ch ();

  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          stall_pct;
  int          hold_requests;
  int          bad_pct;
  logic [31:0] clock_s;

  windowed_sensor_average_reporter u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (window_ch),
    .regs    (reg_ch)
  );

  wsar_window_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .samples    (sample_ch),
    .results    (window_ch),
    .regs       (reg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // result receiver: random stalls plus long hold-offs on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    window_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        window_ch.ready <= 1'b0;
      end else begin
        window_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic sample_t make_sample(bit ok, logic signed [11:0] val,
                                          logic [31:0] now, bit link);
    sample_t s;
    s.read_ok      = ok;
    s.sample_value = val;
    s.now_seconds  = now;
    s.link_ready   = link;
    return s;
  endfunction

  // random sample word; time mostly ticks by a second, sometimes jumps
  function automatic sample_t next_random_sample();
    logic signed [11:0] val;
    int                 roll;
    roll = $urandom_range(99);
    if (roll < 70) clock_s += 32'd1;
    else if (roll < 90) clock_s += $urandom_range(0, 3);
    else if (roll < 98) clock_s += $urandom_range(4, 90);
    else clock_s = $urandom();
    if ($urandom_range(1)) val = 12'($urandom());
    else val = 12'($urandom_range(0, 2880) - 880);
    return make_sample($urandom_range(99) >= bad_pct, val, clock_s, $urandom_range(99) < 80);
  endfunction

  // offer one word, hold it until taken, then maybe go idle
  task automatic send_sample(input sample_t s);
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= s;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic run_items(input int count);
    repeat (count) send_sample(next_random_sample());
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    do @(posedge clk); while (reg_ch.ready !== 1'b1);
    reg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait until every predicted window has come out
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst             <= 1'b1;
    sample_ch.valid <= 1'b0;
    sample_ch.data  <= '0;
    reg_ch.valid    <= 1'b0;
    reg_ch.index    <= REG_WINDOW_LENGTH;
    reg_ch.data     <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests = 0;
    bad_pct       = 15;
    clock_s       = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: window of 5, deadband 26, heartbeat 30
    // field extremes, report on first window
    send_sample(make_sample(1, 12'sh7FF, 0, 0));
    send_sample(make_sample(1, 12'sh800, 1, 0));
    send_sample(make_sample(1, 12'sd2000, 2, 0));
    send_sample(make_sample(1, -12'sd880, 3, 0));
    send_sample(make_sample(1, 12'sd0, 4, 1));
    // all readings bad: empty window, average held
    send_sample(make_sample(0, 12'sh555, 5, 1));
    send_sample(make_sample(0, 12'shAAA, 6, 1));
    send_sample(make_sample(0, 12'sh7FF, 7, 1));
    send_sample(make_sample(0, 12'sh800, 8, 1));
    send_sample(make_sample(0, 12'sh000, 9, 1));
    // negative average truncated toward zero, report wanted but link down
    send_sample(make_sample(1, -12'sd1, 10, 1));
    send_sample(make_sample(0, 12'sd0, 11, 1));
    send_sample(make_sample(1, 12'sd0, 12, 1));
    send_sample(make_sample(1, 12'sd0, 13, 1));
    send_sample(make_sample(0, 12'sd0, 14, 0));
    // top of the time counter, largest average
    send_sample(make_sample(1, 12'sh7FF, 32'hFFFF_FFFB, 1));
    send_sample(make_sample(1, 12'sh7FF, 32'hFFFF_FFFC, 1));
    send_sample(make_sample(1, 12'sh7FF, 32'hFFFF_FFFD, 1));
    send_sample(make_sample(1, 12'sh7FF, 32'hFFFF_FFFE, 1));
    send_sample(make_sample(1, 12'sh7FF, 32'hFFFF_FFFF, 1));
    // time wraps, small move inside deadband: no report
    send_sample(make_sample(1, 12'sd2046, 0, 1));
    send_sample(make_sample(1, 12'sh7FF, 1, 1));
    send_sample(make_sample(1, 12'sh7FF, 2, 1));
    send_sample(make_sample(1, 12'sh7FF, 3, 1));
    send_sample(make_sample(1, 12'sh7FF, 4, 1));
    settle();
    write_reg(REG_UNUSED, 16'hFFFF);

    // random phases over idle patterns and register settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      for (int k = 0; k < 2; k++) begin
        settle();
        if (ph == 0 && k == 0) begin
          // length 0 acts as 1, widest deadband, heartbeat 0
          write_reg(REG_WINDOW_LENGTH, 16'hFFE0);
          write_reg(REG_DEADBAND, 16'hFFFF);
          write_reg(REG_HEARTBEAT, 16'h0000);
        end else if (ph == 1 && k == 0) begin
          // length 31 acts as the maximum, zero deadband, longest heartbeat
          write_reg(REG_WINDOW_LENGTH, 16'h001F);
          write_reg(REG_DEADBAND, 16'h0000);
          write_reg(REG_HEARTBEAT, 16'hFFFF);
        end else begin
          write_reg(REG_WINDOW_LENGTH, {11'($urandom()), 5'($urandom_range(1, 16))});
          if ($urandom_range(1)) write_reg(REG_DEADBAND, 16'($urandom_range(0, 300)));
          else write_reg(REG_DEADBAND, 16'($urandom()));
          case ($urandom_range(4))
            0, 1: write_reg(REG_HEARTBEAT, 16'($urandom_range(0, 10)));
            2, 3: write_reg(REG_HEARTBEAT, 16'($urandom_range(10, 200)));
            default: write_reg(REG_HEARTBEAT, 16'($urandom()));
          endcase
        end
        case ($urandom_range(3))
          0: bad_pct = 5;
          1: bad_pct = 60;
          default: bad_pct = 15;
        endcase
        if ($urandom_range(3) == 0) clock_s = $urandom();
        run_items(90);
        // long receiver hold-off while the sender keeps pushing
        if (ph == 0 && k == 0) begin
          hold_requests++;
          run_items(40);
        end
      end
    end

    // longest window: all readings bad, then all good
    settle();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_reg(REG_WINDOW_LENGTH, 16'd16);
    bad_pct = 100;
    run_items(32);
    bad_pct = 0;
    run_items(32);

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
